// ----- src/ric_pkg.sv -----
// ----------------------------------------------------------------------------
// ric_pkg
// Shared widths, codes and the table entry layout of the inode cache.
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int DEV_W  = 16;
  localparam int INO_W  = 13;
  localparam int SLOT_W = 5;
  localparam int ST_W   = 3;
  localparam int SEC_W  = 13;
  localparam int OFF_W  = 9;
  localparam int CNT_W  = 8;
  localparam int IMAP_W = 8;
  localparam int SMAP_W = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMAP = 1'd1;

  localparam logic [SEC_W-1:0] SEC_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [ST_W-1:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_NULL   = 3'd2,
    ST_FULL   = 3'd3,
    ST_RELERR = 3'd4
  } status_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    logic [CNT_W-1:0] cnt;
  } ent_t;

endpackage

// ----- src/ric_table.sv -----
// ----------------------------------------------------------------------------
// ric_table
// Slot table memory with one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module ric_table #(
  parameter int ENTRIES = 32,
  parameter int IDX_W   = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  ric_pkg::ent_t      wdata,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output ric_pkg::ent_t      rd_data
);

  ric_pkg::ent_t mem [ENTRIES];
  ric_pkg::ent_t rd_q_r;
  logic [ENTRIES-1:0] valid_r;
  logic rv_r;

  // A slot never written since reset reads as free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
      rv_r   <= valid_r[rd_addr];
    end
  end

  assign rd_data = '{dev: rd_q_r.dev, ino: rd_q_r.ino,
                     cnt: rv_r ? rd_q_r.cnt : '0};

endmodule

// ----- src/ric_locate.sv -----
// ----------------------------------------------------------------------------
// ric_locate
// Sector and byte offset of an inode, by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module ric_locate #(
  parameter int SECTOR_BYTES = 512,
  parameter int INODE_BYTES  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ric_pkg::INO_W-1:0]   k,
  input  logic [ric_pkg::IMAP_W-1:0]  imap,
  input  logic [ric_pkg::SMAP_W-1:0]  smap,
  output logic                        done,
  output logic [ric_pkg::SEC_W-1:0]   sector,
  output logic [ric_pkg::OFF_W-1:0]   offset
);

  localparam int PER_RAW = SECTOR_BYTES / INODE_BYTES;
  localparam int PER     = (PER_RAW == 0) ? 1 : PER_RAW;
  localparam int REM_W   = $clog2(PER) + 1;
  localparam int SHIFT   = ric_pkg::INO_W + $clog2(PER);
  localparam int RCP_W   = ric_pkg::INO_W + 1;
  localparam int PRD_W   = ric_pkg::INO_W + RCP_W;
  localparam int RCP     = ((1 << SHIFT) + PER - 1) / PER;
  localparam int MUL_W   = REM_W + 9;
  localparam int SUM_W   = ric_pkg::SEC_W + 1;

  logic [ric_pkg::INO_W-1:0] k_r;
  logic [ric_pkg::INO_W-1:0] k1_r;
  logic [ric_pkg::INO_W-1:0] q_r;
  logic [REM_W-1:0]          rem_r;
  logic [SUM_W-1:0]          sum_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      done_r;
  logic [PRD_W-1:0]          prd;
  logic [ric_pkg::INO_W-1:0] qp;
  logic [ric_pkg::INO_W-1:0] rem_full;
  logic [MUL_W-1:0]          prod;

  // The rounded-up reciprocal gives the exact quotient for every 13-bit k.
  assign prd      = PRD_W'(k_r) * PRD_W'(RCP);
  assign qp       = q_r * ric_pkg::INO_W'(PER);
  assign rem_full = k1_r - qp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      if (start) begin
        done_r <= 1'b0;
      end else if (v2_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r <= k;
    end
    if (v1_r) begin
      k1_r <= k_r;
      q_r  <= ric_pkg::INO_W'(prd >> SHIFT);
    end
    if (v2_r) begin
      rem_r <= rem_full[REM_W-1:0];
      sum_r <= SUM_W'(2) + SUM_W'(imap) + SUM_W'(smap) + SUM_W'(q_r);
    end
  end

  assign prod = MUL_W'(rem_r) * MUL_W'(INODE_BYTES);

  assign done   = done_r;
  assign sector = (sum_r > SUM_W'(ric_pkg::SEC_MAX)) ? ric_pkg::SEC_MAX
                                                     : sum_r[ric_pkg::SEC_W-1:0];
  assign offset = prod[ric_pkg::OFF_W-1:0];

endmodule

// ----- src/refcounted_inode_cache.sv -----
// A hit on slot i gives its result once the scan has read slot i, a miss (allocation or
// full table) once it has read every slot; a release reads its slot once, a null request none.
// Throughput: one word at a time; the next word can be accepted in the same cycle the result
// appears. The slot scan issues one table read per cycle.
// Reset: synchronous, clears the slot valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_inode_cache
// Reference-counted inode slot table with acquire, release and sector lookup.
// ----------------------------------------------------------------------------
module refcounted_inode_cache #(
  parameter int TABLE_ENTRIES = 32,
  parameter int SECTOR_BYTES  = 512,
  parameter int INODE_BYTES   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // device[15:0], inode_number[28:16], slot[33:29], zero fill
  input  logic [39:0]                        in_tdata,
  // action[0]
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot_index[4:0], sector[17:5], byte_offset[26:18], ref_count[34:27], zero fill
  output logic [39:0]                        out_tdata,
  // status[2:0]
  output logic [ric_pkg::ST_W-1:0]           out_tuser,
  input  logic                               cfg_we,
  input  logic [ric_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ric_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_REL, S_SCAN, S_EMIT} state_t;

  state_t                        state_r, state_nxt;
  logic [ric_pkg::IMAP_W-1:0]    imap_r;
  logic [ric_pkg::SMAP_W-1:0]    smap_r;
  logic [ric_pkg::DEV_W-1:0]     dev_r, dev_nxt;
  logic [ric_pkg::INO_W-1:0]     ino_r, ino_nxt;
  ric_pkg::status_t              res_st_r, res_st_nxt;
  logic [ric_pkg::SLOT_W-1:0]    res_idx_r, res_idx_nxt;
  logic [ric_pkg::CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                          res_loc_r, res_loc_nxt;
  logic [IDX_W:0]                issue_r, issue_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]              chk_idx_r, chk_idx_nxt;
  logic                          free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]              free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]              rel_idx_r, rel_idx_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [39:0]                   out_tdata_r, out_tdata_nxt;
  logic [ric_pkg::ST_W-1:0]      out_tuser_r, out_tuser_nxt;

  logic                          tbl_we;
  logic [IDX_W-1:0]              tbl_waddr;
  ric_pkg::ent_t                 tbl_wdata;
  logic                          tbl_rd_en;
  logic [IDX_W-1:0]              tbl_rd_addr;
  ric_pkg::ent_t                 tbl_rd_data;

  logic                          loc_start;
  logic                          loc_done;
  logic [ric_pkg::SEC_W-1:0]     loc_sector;
  logic [ric_pkg::OFF_W-1:0]     loc_offset;

  logic                          in_acc;
  logic                          in_action;
  logic [ric_pkg::DEV_W-1:0]     in_dev;
  logic [ric_pkg::INO_W-1:0]     in_ino;
  logic [ric_pkg::SLOT_W-1:0]    in_slot;
  logic                          slot_ok;
  logic                          hit;
  logic                          free_now;
  logic                          last;
  logic                          out_free;

  assign in_action = in_tuser[0];
  assign in_dev    = in_tdata[15:0];
  assign in_ino    = in_tdata[28:16];
  assign in_slot   = in_tdata[33:29];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_ok   = ({27'd0, in_slot} < 32'(TABLE_ENTRIES));
  assign loc_start = in_acc;
  assign out_free  = !out_tvalid_r || out_tready;

  assign hit      = chk_vld_r && (tbl_rd_data.cnt != '0) &&
                    (tbl_rd_data.dev == dev_r) && (tbl_rd_data.ino == ino_r);
  assign free_now = chk_vld_r && (tbl_rd_data.cnt == '0);
  assign last     = chk_vld_r && (chk_idx_r == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imap_r <= ric_pkg::IMAP_W'(1);
      smap_r <= ric_pkg::SMAP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ric_pkg::CFG_IMAP: imap_r <= cfg_wdata[ric_pkg::IMAP_W-1:0];
        ric_pkg::CFG_SMAP: smap_r <= cfg_wdata[ric_pkg::SMAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dev_nxt        = dev_r;
    ino_nxt        = ino_r;
    res_st_nxt     = res_st_r;
    res_idx_nxt    = res_idx_r;
    res_cnt_nxt    = res_cnt_r;
    res_loc_nxt    = res_loc_r;
    issue_nxt      = issue_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    rel_idx_nxt    = rel_idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    tbl_we         = 1'b0;
    tbl_waddr      = chk_idx_r;
    tbl_wdata      = tbl_rd_data;
    tbl_rd_en      = 1'b0;
    tbl_rd_addr    = issue_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dev_nxt      = in_dev;
          ino_nxt      = in_ino;
          res_idx_nxt  = '0;
          res_cnt_nxt  = '0;
          res_loc_nxt  = 1'b0;
          issue_nxt    = '0;
          free_vld_nxt = 1'b0;
          rel_idx_nxt  = IDX_W'(in_slot);
          if (in_action) begin
            res_idx_nxt = in_slot;
            if (slot_ok) begin
              tbl_rd_en   = 1'b1;
              tbl_rd_addr = IDX_W'(in_slot);
              state_nxt   = S_REL;
            end else begin
              res_st_nxt = ric_pkg::ST_RELERR;
              state_nxt  = S_EMIT;
            end
          end else if (in_ino == '0) begin
            res_st_nxt = ric_pkg::ST_NULL;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_REL: begin
        if (tbl_rd_data.cnt == '0) begin
          res_st_nxt = ric_pkg::ST_RELERR;
        end else begin
          tbl_we        = 1'b1;
          tbl_waddr     = rel_idx_r;
          tbl_wdata.cnt = tbl_rd_data.cnt - 1'b1;
          res_st_nxt    = ric_pkg::ST_HIT;
          res_cnt_nxt   = tbl_rd_data.cnt - 1'b1;
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (issue_r < (IDX_W+1)'(TABLE_ENTRIES)) begin
          tbl_rd_en = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end
        chk_vld_nxt = tbl_rd_en;
        chk_idx_nxt = issue_r[IDX_W-1:0];
        if (hit) begin
          tbl_we        = 1'b1;
          tbl_wdata.cnt = (tbl_rd_data.cnt == ric_pkg::CNT_MAX) ? ric_pkg::CNT_MAX
                                                              : tbl_rd_data.cnt + 1'b1;
          res_st_nxt    = ric_pkg::ST_HIT;
          res_idx_nxt   = ric_pkg::SLOT_W'(chk_idx_r);
          res_cnt_nxt   = tbl_wdata.cnt;
          res_loc_nxt   = 1'b1;
          chk_vld_nxt   = 1'b0;
          state_nxt     = S_EMIT;
        end else if (last) begin
          if (free_vld_r || free_now) begin
            tbl_we      = 1'b1;
            tbl_waddr   = free_vld_r ? free_idx_r : chk_idx_r;
            tbl_wdata   = '{dev: dev_r, ino: ino_r, cnt: ric_pkg::CNT_W'(1)};
            res_st_nxt  = ric_pkg::ST_NEW;
            res_idx_nxt = ric_pkg::SLOT_W'(tbl_waddr);
            res_cnt_nxt = ric_pkg::CNT_W'(1);
            res_loc_nxt = 1'b1;
          end else begin
            res_st_nxt = ric_pkg::ST_FULL;
          end
          chk_vld_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else if (free_now && !free_vld_r) begin
          free_vld_nxt = 1'b1;
          free_idx_nxt = chk_idx_r;
        end
      end
      S_EMIT: begin
        if ((!res_loc_r || loc_done) && out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_st_r;
          out_tdata_nxt  = {5'd0, res_cnt_r,
                            res_loc_r ? loc_offset : ric_pkg::OFF_W'(0),
                            res_loc_r ? loc_sector : ric_pkg::SEC_W'(0),
                            res_idx_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      free_vld_r   <= 1'b0;
      issue_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      free_vld_r   <= free_vld_nxt;
      issue_r      <= issue_nxt;
    end
    dev_r       <= dev_nxt;
    ino_r       <= ino_nxt;
    res_st_r    <= res_st_nxt;
    res_idx_r   <= res_idx_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_loc_r   <= res_loc_nxt;
    chk_idx_r   <= chk_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    rel_idx_r   <= rel_idx_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  ric_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  ric_locate #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .INODE_BYTES  (INODE_BYTES)
  ) u_locate (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (loc_start),
    .k      (in_ino - 1'b1),
    .imap   (imap_r),
    .smap   (smap_r),
    .done   (loc_done),
    .sector (loc_sector),
    .offset (loc_offset)
  );

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r == S_REL || state_r == S_SCAN))
    else $error("table written outside release or scan");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second word taken while a request is in progress");

  a_new_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ric_pkg::ST_NEW) |-> (out_tdata[34:27] == 8'd1))
    else $error("new slot does not report a count of one");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ric_pkg::ST_NULL || out_tuser == ric_pkg::ST_FULL))
      |-> (out_tdata == '0))
    else $error("null or full result carries nonzero fields");

endmodule
